>>> src/sha1_pkg.sv
`timescale 1ns / 1ps
package sha1_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] K0 = 32'h5a827999;
  localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
  localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
  localparam logic [WordW-1:0] K3 = 32'hca62c1d6;
  localparam logic [WordW-1:0] Iv0 = 32'h67452301;
  localparam logic [WordW-1:0] Iv1 = 32'hefcdab89;
  localparam logic [WordW-1:0] Iv2 = 32'h98badcfe;
  localparam logic [WordW-1:0] Iv3 = 32'h10325476;
  localparam logic [WordW-1:0] Iv4 = 32'hc3d2e1f0;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic REQ_ABSORB = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // Back-end states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } core_state_t;

  // Entry of the queue between front and back.
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } req_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (WordW - n));
  endfunction

endpackage

>>> src/sha1_req_fifo.sv
`timescale 1ns / 1ps
module sha1_req_fifo
  import sha1_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_data,
  output logic full,
  input  logic pop,
  output req_t pop_data,
  output logic empty
);

  req_t       mem [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 2'd1;
      if (pop && !empty) rptr <= rptr + 2'd1;
      count <= count + {2'b0, push && !full} - {2'b0, pop && !empty};
    end
  end

endmodule

>>> src/sha1_core.sv
`timescale 1ns / 1ps
module sha1_core
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_take,
  output logic        out_valid,
  output logic [31:0] out_word,
  output logic        out_last,
  input  logic        out_take
);

  core_state_t state;
  core_state_t state_next;

  logic [31:0] h [5];
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic [6:0]  round;
  logic [2:0]  emit_idx;
  logic        finishing;
  logic        need_len;

  logic [31:0] f, k, t, wn, wcur;
  logic [63:0] bits;
  logic [31:0] cur_word;
  logic        full_byte;

  assign bits = {msg_bytes, 3'b000};
  assign cur_word = w[15];

  // Byte shifts into the low end of the newest window word; words roll down.
  always_comb begin
    wn = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
    wcur = (round < 7'd16) ? w[0] : wn;
    priority if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t = rotl(a, 5) + f + e + k + wcur;
  end

  assign full_byte = (fill == 6'd63);
  assign req_take = (state == ST_IDLE) && req_valid;
  assign out_valid = (state == ST_EMIT);
  assign out_word = h[0];
  assign out_last = (emit_idx == 3'd4);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.finish == REQ_FINISH) begin
            // A pad in the last byte fills the block; a pad in byte 55 leaves
            // exactly the room for the length.
            if (full_byte) state_next = ST_ROUND;
            else if (fill == 6'd55) state_next = ST_LEN;
            else state_next = ST_PAD;
          end else if (full_byte) state_next = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (fill == 6'd63) state_next = ST_ROUND;
        else if (fill == 6'd55 && need_len) state_next = ST_LEN;
      end
      ST_LEN: if (fill == 6'd63) state_next = ST_ROUND;
      ST_ROUND: if (round == 7'd79) state_next = ST_ADD;
      ST_ADD: begin
        if (!finishing) state_next = ST_IDLE;
        else if (need_len) state_next = ST_PAD;
        else state_next = ST_EMIT;
      end
      ST_EMIT: if (out_take && emit_idx == 3'd4) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      h[0] <= Iv0; h[1] <= Iv1; h[2] <= Iv2; h[3] <= Iv3; h[4] <= Iv4;
      fill <= '0;
      msg_bytes <= '0;
      round <= '0;
      emit_idx <= '0;
      finishing <= 1'b0;
      need_len <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            if (req.finish == REQ_FINISH) begin
              w[15] <= {cur_word[23:0], PadByte};
              finishing <= 1'b1;
              need_len <= (fill != 6'd55);
              if (fill[1:0] == 2'd0) begin
                for (int i = 0; i < 15; i++) w[i] <= w[i+1];
              end
              fill <= fill + 6'd1;
            end else begin
              w[15] <= {cur_word[23:0], req.data};
              if (fill[1:0] == 2'd0) begin
                for (int i = 0; i < 15; i++) w[i] <= w[i+1];
              end
              fill <= fill + 6'd1;
              msg_bytes <= msg_bytes + 61'd1;
            end
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            round <= '0;
          end
        end
        ST_PAD, ST_LEN: begin
          if (state == ST_LEN) begin
            w[15] <= {cur_word[23:0], bits[8*(63-fill) +: 8]};
          end else begin
            w[15] <= {cur_word[23:0], 8'h00};
            if (fill == 6'd55 && need_len) need_len <= 1'b0;
          end
          if (fill[1:0] == 2'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          end
          fill <= fill + 6'd1;
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          round <= '0;
        end
        ST_ROUND: begin
          // The window rolls one word per round; rounds 0-15 use the oldest word, later rounds the expanded word wn.
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wcur;
          a <= t; b <= a; c <= rotl(b, 30); d <= c; e <= d;
          round <= round + 7'd1;
        end
        ST_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          emit_idx <= '0;
          // A pad that landed past byte 55 needs a second block.
          if (finishing && need_len) need_len <= 1'b1;
        end
        ST_EMIT: begin
          if (out_take) begin
            h[0] <= h[1]; h[1] <= h[2]; h[2] <= h[3]; h[3] <= h[4]; h[4] <= h[0];
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd4) begin
              h[0] <= Iv0; h[1] <= Iv1; h[2] <= Iv2; h[3] <= Iv3; h[4] <= Iv4;
              fill <= '0;
              msg_bytes <= '0;
              finishing <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/sha1_out_fifo.sv
`timescale 1ns / 1ps
module sha1_out_fifo
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] in_word,
  input  logic        in_last,
  output logic        in_take,
  output logic [31:0] digest_word,
  output logic        word_last,
  output logic        empty,
  input  logic        pop
);

  logic        held;
  logic [31:0] word_q;
  logic        last_q;

  assign in_take = in_valid && (!held || pop);
  assign empty = !held;
  assign digest_word = word_q;
  assign word_last = last_q;

  always_ff @(posedge clk) begin
    if (in_take) begin
      word_q <= in_word;
      last_q <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) held <= 1'b0;
    else if (in_take) held <= 1'b1;
    else if (pop) held <= 1'b0;
  end

endmodule

>>> src/sha1_stream_hash_unit.sv
`timescale 1ns / 1ps
// Streaming SHA-1 hash unit.
// Input channel: push/full carry one transaction per message byte
// (req_type 0, data_byte) or a finish request (req_type 1).
// Result channel: empty/pop; each finish yields five digest words, h0 first,
// the fifth with word_last set.
// A four-entry request queue decouples the front from the hashing core.
// The core takes message bytes while idle; every 64th byte starts a
// compression (80 rounds plus the chain add), during which it takes none.
// A finish runs the padding bytes one a cycle and one or two compressions
// before the first word appears; the five words then leave one a cycle
// while the receiver pops. Reset is synchronous: the chain value returns
// to the initial vector and the byte counts clear. When the receiver
// stalls, the output register holds its word and the core waits; input
// keeps queuing until the queue is full.
module sha1_stream_hash_unit
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic        word_last
);

  req_t        q_in, q_out;
  logic        q_empty, q_take;
  logic        c_valid, c_last, c_take;
  logic [31:0] c_word;

  assign q_in.finish = req_type;
  assign q_in.data = data_byte;

  sha1_req_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(q_in), .full(full),
    .pop(q_take), .pop_data(q_out), .empty(q_empty)
  );

  sha1_core u_core (
    .clk(clk), .rst(rst), .req_valid(!q_empty), .req(q_out), .req_take(q_take),
    .out_valid(c_valid), .out_word(c_word), .out_last(c_last), .out_take(c_take)
  );

  sha1_out_fifo u_out (
    .clk(clk), .rst(rst), .in_valid(c_valid), .in_word(c_word), .in_last(c_last),
    .in_take(c_take), .digest_word(digest_word), .word_last(word_last),
    .empty(empty), .pop(pop)
  );

endmodule

>>> dv/sha1_stream_hash_unit_test.sv
`timescale 1ns / 1ps
module sha1_stream_hash_unit_test;
  import sha1_pkg::*;

  class digest_board;
    logic [31:0] cv[5];
    logic [7:0] blk[64];
    int unsigned fill;
    logic [60:0] nbytes;
    logic [31:0] want_word[$];
    logic want_last[$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      cv[0] = Iv0; cv[1] = Iv1; cv[2] = Iv2; cv[3] = Iv3; cv[4] = Iv4;
      fill = 0;
      nbytes = '0;
    endfunction

    function void compress();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3]; e = cv[4];
      for (int r = 0; r < 80; r++) begin
        if (r >= 16) begin
          t = w[(r-3)%16] ^ w[(r-8)%16] ^ w[(r-14)%16] ^ w[r%16];
          w[r%16] = {t[30:0], t[31]};
        end
        if (r < 20) begin
          f = (b & c) | (~b & d); k = K0;
        end else if (r < 40) begin
          f = b ^ c ^ d; k = K1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d); k = K2;
        end else begin
          f = b ^ c ^ d; k = K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[r%16];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      cv[0] += a; cv[1] += b; cv[2] += c; cv[3] += d; cv[4] += e;
    endfunction

    function void note_request(logic kind, logic [7:0] value);
      logic [63:0] bits;
      if (kind == REQ_ABSORB) begin
        blk[fill] = value;
        fill = (fill + 1) % 64;
        nbytes++;
        if (fill == 0) compress();
        return;
      end
      bits = {nbytes, 3'b000};
      blk[fill] = PadByte;
      fill = (fill + 1) % 64;
      if (fill == 0 || fill > 56) begin
        while (fill != 0) begin
          blk[fill] = 8'h00;
          fill = (fill + 1) % 64;
        end
        compress();
      end
      while (fill < 56) begin
        blk[fill] = 8'h00;
        fill++;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 5; i++) begin
        want_word.insert(want_word.size(), cv[i]);
        want_last.insert(want_last.size(), i == 4);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic last);
      if (want_word.size() == 0) begin
        $error("digest_word %h arrived with nothing expected", word);
        errors++;
        return;
      end
      if (word !== want_word[0]) begin
        $error("digest_word: expected %h, actual %h", want_word[0], word);
        errors++;
      end
      if (last !== want_last[0]) begin
        $error("word_last: expected %b, actual %b", want_last[0], last);
        errors++;
      end
      void'(want_word.pop_front());
      void'(want_last.pop_front());
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic req_type = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic pop = 1'b0;
  logic full, empty, word_last;
  logic [31:0] digest_word;

  digest_board board = new();
  bit steady_send = 1'b0;
  bit steady_recv = 1'b0;
  bit recv_on = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sha1_stream_hash_unit u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .data_byte(data_byte), .empty(empty), .pop(pop),
    .digest_word(digest_word), .word_last(word_last)
  );

  // Unless steady_send is set, random idle cycles are inserted ahead of each
  // transaction; push then stays high until the block takes it.
  task automatic send_request(logic kind, logic [7:0] value);
    if (!steady_send) begin
      while ($urandom_range(99) < 31) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    req_type <= kind;
    data_byte <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_request(kind, value);
  endtask

  task automatic send_message(int unsigned len);
    for (int i = 0; i < len; i++) send_request(REQ_ABSORB, 8'($urandom));
    send_request(REQ_FINISH, 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (recv_on) begin
      if (pop && !empty) board.check_word(digest_word, word_last);
      pop <= steady_recv || ($urandom_range(99) >= 31);
    end
  end

  initial begin
    int lens[$];
    int unsigned n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    recv_on <= 1'b1;
    @(posedge clk);

    // Empty message, padding edge lengths and all-ones / all-zeros bytes.
    send_request(REQ_FINISH, 8'hff);
    send_request(REQ_ABSORB, 8'h00);
    send_request(REQ_FINISH, 8'h00);
    send_request(REQ_ABSORB, 8'hff);
    send_request(REQ_ABSORB, 8'h80);
    send_request(REQ_FINISH, 8'hff);
    lens = '{55, 56, 63, 64};
    // Two messages in the middle run with no idling on either side.
    foreach (lens[i]) begin
      steady_send = (i == 1 || i == 2);
      steady_recv = (i >= 1 && i <= 3);
      send_message(lens[i]);
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;
    send_request(REQ_FINISH, 8'h5a);

    n = 0;
    while (n < 20) begin
      int unsigned len;
      len = $urandom_range(0, 12);
      send_message(len);
      n += len + 1;
    end
    push <= 1'b0;

    while (board.want_word.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
